>>> sv/lhbp_pkg.sv
// ----------------------------------------------------------------------------
// lhbp_pkg
// Table sizes, counter constants and the index and update functions of the
// local-history branch predictor.
// ----------------------------------------------------------------------------
package lhbp_pkg;

  localparam int ADDR_BITS      = 12;
  localparam int HIST_IDX_BITS  = 10;
  localparam int HIST_BITS      = 3;
  localparam int CTR_IDX_BITS   = 11;
  localparam int CTR_BITS       = 2;
  localparam int CLR_BITS       = (HIST_IDX_BITS > CTR_IDX_BITS) ? HIST_IDX_BITS
                                                                 : CTR_IDX_BITS;

  localparam logic [CTR_BITS-1:0] CTR_MAX  = CTR_BITS'(3);
  localparam logic [CTR_BITS-1:0] CTR_INIT = CTR_BITS'(2);
  localparam logic [CTR_BITS-1:0] CTR_MID  = CTR_BITS'(3 / 2);

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  typedef logic [HIST_IDX_BITS-1:0] hist_idx_t;
  typedef logic [HIST_BITS-1:0]     hist_t;
  typedef logic [CTR_IDX_BITS-1:0]  ctr_idx_t;
  typedef logic [CTR_BITS-1:0]      ctr_t;
  typedef logic [CLR_BITS-1:0]      clr_idx_t;

  // address bits [11:2], zero above the address
  function automatic hist_idx_t hist_slot(input logic [ADDR_BITS-1:0] addr);
    logic [ADDR_BITS-1:0] shifted;
    begin
      shifted   = addr >> 2;
      hist_slot = HIST_IDX_BITS'(shifted);
    end
  endfunction

  // history index plus local history, wrapping modulo the counter table
  function automatic ctr_idx_t ctr_slot(input hist_idx_t hs, input hist_t h);
    ctr_slot = CTR_IDX_BITS'(hs) + CTR_IDX_BITS'(h);
  endfunction

  function automatic ctr_t ctr_step(input ctr_t ctr, input logic taken);
    ctr_t res;
    begin
      res = ctr;
      if (taken) begin
        if (ctr != CTR_MAX) res = ctr + ctr_t'(1);
      end else begin
        if (ctr != ctr_t'(0)) res = ctr - ctr_t'(1);
      end
      ctr_step = res;
    end
  endfunction

  function automatic hist_t hist_shift(input hist_t h, input logic taken);
    hist_shift = HIST_BITS'({h, taken});
  endfunction

endpackage

>>> sv/lhbp_ram.sv
// ----------------------------------------------------------------------------
// lhbp_ram
// Simple dual-port synchronous RAM: one write port, and one read port
// whose read is registered.
// ----------------------------------------------------------------------------
module lhbp_ram #(
  parameter int WIDTH     = 2,
  parameter int ADDR_BITS = 11
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/local_history_branch_predictor_unit.sv
// ----------------------------------------------------------------------------
// local_history_branch_predictor_unit
// Two-level local-history branch predictor: a history table indexed by
// address bits [11:2] and a table of 2-bit saturating counters indexed by
// history index plus local history.
//
//   channel   handshake          payload
//   request   start / busy       opcode, branch_addr, outcome_taken
//   result    done (one cycle)   predict_taken
//
// A request steps through IDLE (history read), HIST (counter read) and CTR
// (result or write-back); a new request is accepted only once back in IDLE.
// The two table reads are dependent, each through a registered memory port.
// After reset a clearing pass that steps clr_idx over every table address
// holds busy high while both tables are written with their initial values.
// An update request gives no result; done is never held off by the receiver.
// ----------------------------------------------------------------------------
module local_history_branch_predictor_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode,
  input  logic [lhbp_pkg::ADDR_BITS-1:0]    branch_addr,
  input  logic                              outcome_taken,
  output logic                              done,
  output logic                              predict_taken
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_HIST  = 2'd2;
  localparam logic [1:0] S_CTR   = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  lhbp_pkg::clr_idx_t  clr_idx;
  logic                op_q;
  logic                taken_q;
  lhbp_pkg::hist_idx_t hslot_q;
  lhbp_pkg::hist_t     hist_q;
  lhbp_pkg::ctr_idx_t  cslot_q;

  lhbp_pkg::hist_idx_t hist_raddr;
  lhbp_pkg::hist_t     hist_rdata;
  logic                hist_we;
  lhbp_pkg::hist_idx_t hist_waddr;
  lhbp_pkg::hist_t     hist_wdata;

  lhbp_pkg::ctr_idx_t  ctr_raddr;
  lhbp_pkg::ctr_t      ctr_rdata;
  logic                ctr_we;
  lhbp_pkg::ctr_idx_t  ctr_waddr;
  lhbp_pkg::ctr_t      ctr_wdata;

  logic                accept;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign hist_raddr = lhbp_pkg::hist_slot(branch_addr);
  assign ctr_raddr  = lhbp_pkg::ctr_slot(hslot_q, hist_rdata);

  lhbp_ram #(
    .WIDTH     (lhbp_pkg::HIST_BITS),
    .ADDR_BITS (lhbp_pkg::HIST_IDX_BITS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  lhbp_ram #(
    .WIDTH     (lhbp_pkg::CTR_BITS),
    .ADDR_BITS (lhbp_pkg::CTR_IDX_BITS)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  // write ports: clearing pass, or write-back of an update
  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = hslot_q;
    hist_wdata = lhbp_pkg::hist_shift(hist_q, taken_q);
    ctr_we     = 1'b0;
    ctr_waddr  = cslot_q;
    ctr_wdata  = lhbp_pkg::ctr_step(ctr_rdata, taken_q);
    unique case (state)
      S_CLEAR: begin
        hist_we    = ((clr_idx >> lhbp_pkg::HIST_IDX_BITS) == '0);
        hist_waddr = lhbp_pkg::HIST_IDX_BITS'(clr_idx);
        hist_wdata = '0;
        ctr_we     = ((clr_idx >> lhbp_pkg::CTR_IDX_BITS) == '0);
        ctr_waddr  = lhbp_pkg::CTR_IDX_BITS'(clr_idx);
        ctr_wdata  = lhbp_pkg::CTR_INIT;
      end
      S_CTR: begin
        hist_we = (op_q == lhbp_pkg::OP_UPDATE);
        ctr_we  = (op_q == lhbp_pkg::OP_UPDATE);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_idx == '1) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_HIST;
      S_HIST:  state_next = S_CTR;
      S_CTR:   state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= lhbp_pkg::CLR_BITS'(clr_idx + 1'b1);
      end
      done <= (state == S_CTR) && (op_q == lhbp_pkg::OP_PREDICT);
    end
  end

  // request payload and intermediate lookups
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= opcode;
      taken_q <= outcome_taken;
      hslot_q <= hist_raddr;
    end
    if (state == S_HIST) begin
      hist_q  <= hist_rdata;
      cslot_q <= ctr_raddr;
    end
    if (state == S_CTR) begin
      predict_taken <= (ctr_rdata > lhbp_pkg::CTR_MID);
    end
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe outside idle");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_CTR && $past(op_q) == lhbp_pkg::OP_PREDICT)
    else $error("result strobe without a predict lookup");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_HIST) |-> !hist_we && !ctr_we)
    else $error("table write outside clear or write-back");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_HIST)
    else $error("accepted request did not start a lookup");
`endif

endmodule
